FILE: src/cbgm_pkg.sv
`default_nettype none

package cbgm_pkg;

  // defaults for the top-level parameters
  localparam int unsigned TableDepthDef = 64;
  localparam int unsigned PointBitsDef  = 16;

  // fixed port widths
  localparam int unsigned ReqW    = 2;
  localparam int unsigned IdW     = 16;
  localparam int unsigned PtW     = 16;
  localparam int unsigned StatusW = 2;

  // depth of the command queue between front and back
  localparam int unsigned CmdQDepth = 2;

  // request codes on req_type
  localparam logic [ReqW-1:0] REQ_LOAD  = 2'd0;
  localparam logic [ReqW-1:0] REQ_MATCH = 2'd1;
  localparam logic [ReqW-1:0] REQ_CLEAR = 2'd2;
  localparam logic [ReqW-1:0] REQ_SPARE = 2'd3;

  // result codes on status
  localparam logic [StatusW-1:0] ST_OK      = 2'd0;
  localparam logic [StatusW-1:0] ST_MATCHED = 2'd1;
  localparam logic [StatusW-1:0] ST_NOMATCH = 2'd2;
  localparam logic [StatusW-1:0] ST_FULL    = 2'd3;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_MATCH,
    OP_CLEAR,
    OP_NOP
  } cmd_op_e;

  // classified command, points already masked to the point width
  typedef struct packed {
    cmd_op_e        op;
    logic [IdW-1:0] id;
    logic [PtW-1:0] int_start;
    logic [PtW-1:0] int_end;
    logic [PtW-1:0] point;
  } cmd_t;

endpackage

`default_nettype wire

FILE: src/cbgm_front.sv
`default_nettype none

module cbgm_front import cbgm_pkg::*; #(
  parameter int unsigned POINT_BITS = PointBitsDef
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            req_valid_i,
  output logic                 req_ready_o,
  input  wire logic [ReqW-1:0] req_type_i,
  input  wire logic [IdW-1:0]  interval_id_i,
  input  wire logic [PtW-1:0]  interval_start_i,
  input  wire logic [PtW-1:0]  interval_end_i,
  input  wire logic [PtW-1:0]  query_point_i,
  output logic                 cmd_valid_o,
  output cmd_t                 cmd_o,
  input  wire logic            cmd_pop_i
);

  localparam int unsigned PW  = (POINT_BITS < PtW) ? POINT_BITS : PtW;
  localparam logic [PtW-1:0] PtMask = PtW'((64'd1 << PW) - 64'd1);
  localparam int unsigned QAW = (CmdQDepth > 1) ? $clog2(CmdQDepth) : 1;
  localparam int unsigned QCW = $clog2(CmdQDepth + 1);

  cmd_t           cmd_new;
  cmd_t           q_mem_q [CmdQDepth];
  logic [QAW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QAW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCW-1:0] count_q, count_d;
  logic           push, pop;

  // classify the word
  always_comb begin
    cmd_new.id        = interval_id_i;
    cmd_new.int_start = interval_start_i & PtMask;
    cmd_new.int_end   = interval_end_i & PtMask;
    cmd_new.point     = query_point_i & PtMask;
    unique case (req_type_i)
      REQ_LOAD:  cmd_new.op = OP_LOAD;
      REQ_MATCH: cmd_new.op = OP_MATCH;
      REQ_CLEAR: cmd_new.op = OP_CLEAR;
      REQ_SPARE: cmd_new.op = OP_NOP;
      default:   cmd_new.op = OP_NOP;
    endcase
  end

  assign req_ready_o = (count_q != QCW'(CmdQDepth));
  assign push        = req_valid_i & req_ready_o;
  assign cmd_valid_o = (count_q != '0);
  assign pop         = cmd_pop_i & cmd_valid_o;
  assign cmd_o       = q_mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QAW'(CmdQDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QAW'(CmdQDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= cmd_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

`default_nettype wire

FILE: src/cbgm_back.sv
`default_nettype none

module cbgm_back import cbgm_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TableDepthDef,
  parameter int unsigned POINT_BITS  = PointBitsDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cmd_valid_i,
  input  wire cmd_t               cmd_i,
  output logic                    cmd_pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [StatusW-1:0]      status_o,
  output logic [IdW-1:0]          match_id_o
);

  localparam int unsigned PW = (POINT_BITS < PtW) ? POINT_BITS : PtW;
  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned KW = 2 * PW + IdW;
  localparam int unsigned EW = 1 + KW;

  typedef enum logic [6:0] {
    S_INIT   = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_LOAD   = 7'b0000100,
    S_MATCH  = 7'b0001000,
    S_CLEAR  = 7'b0010000,
    S_REMOVE = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // entry layout: live, end, start, id (key order for the tie-break)
  logic [EW-1:0] mem_q [TABLE_DEPTH];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [EW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [EW-1:0] rd_data_q;

  logic [CW-1:0] cnt_q, cnt_d;
  logic          rd_vld_q, rd_vld_d;
  logic [AW-1:0] rd_idx_q;
  cmd_t          cmd_q, cmd_d;
  logic          found_q, found_d;
  logic [AW-1:0] best_idx_q, best_idx_d;
  logic [KW-1:0] best_key_q, best_key_d;
  logic [StatusW-1:0] res_status_q, res_status_d;
  logic [IdW-1:0]     res_id_q, res_id_d;
  logic               out_vld_q, out_vld_d;
  logic [StatusW-1:0] out_status_q, out_status_d;
  logic [IdW-1:0]     out_id_q, out_id_d;

  logic          e_live;
  logic [KW-1:0] e_key;
  logic [PW-1:0] e_start, e_end, pt;
  logic          scanning, rd_issue, hit, better, scan_done, last_cnt;

  assign e_live  = rd_data_q[EW-1];
  assign e_key   = rd_data_q[KW-1:0];
  assign e_end   = rd_data_q[IdW+PW +: PW];
  assign e_start = rd_data_q[IdW +: PW];
  assign pt      = cmd_q.point[PW-1:0];

  assign scanning  = (state_q == S_LOAD) || (state_q == S_MATCH);
  assign rd_issue  = scanning && (cnt_q < CW'(TABLE_DEPTH));
  assign scan_done = (cnt_q == CW'(TABLE_DEPTH)) && !rd_vld_q;
  assign last_cnt  = (cnt_q == CW'(TABLE_DEPTH - 1));
  assign hit       = rd_vld_q && e_live && (e_start <= pt) && (pt <= e_end);
  assign better    = hit && (!found_q || (e_key < best_key_q));
  assign mem_raddr = cnt_q[AW-1:0];

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    rd_vld_d     = 1'b0;
    cmd_d        = cmd_q;
    found_d      = found_q;
    best_idx_d   = best_idx_q;
    best_key_d   = best_key_q;
    res_status_d = res_status_q;
    res_id_d     = res_id_q;
    cmd_pop_o    = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = cnt_q[AW-1:0];
    mem_wdata    = '0;
    out_vld_d    = out_vld_q & ~out_ready_i;
    out_status_d = out_status_q;
    out_id_d     = out_id_q;

    unique case (state_q)
      S_INIT, S_CLEAR: begin
        // sweep every slot to not-live
        mem_we = 1'b1;
        cnt_d  = cnt_q + 1'b1;
        if (last_cnt) begin
          res_status_d = ST_OK;
          res_id_d     = '0;
          state_d      = (state_q == S_INIT) ? S_IDLE : S_DONE;
        end
      end
      S_IDLE: begin
        cnt_d   = '0;
        found_d = 1'b0;
        if (cmd_valid_i) begin
          cmd_pop_o    = 1'b1;
          cmd_d        = cmd_i;
          res_status_d = ST_OK;
          res_id_d     = '0;
          unique case (cmd_i.op)
            OP_LOAD:  state_d = S_LOAD;
            OP_MATCH: state_d = S_MATCH;
            OP_CLEAR: state_d = S_CLEAR;
            OP_NOP:   state_d = S_DONE;
            default:  state_d = S_DONE;
          endcase
        end
      end
      S_LOAD: begin
        rd_vld_d = rd_issue;
        if (rd_issue) begin
          cnt_d = cnt_q + 1'b1;
        end
        if (rd_vld_q && !e_live) begin
          // lowest free slot takes the interval
          mem_we       = 1'b1;
          mem_waddr    = rd_idx_q;
          mem_wdata    = {1'b1, cmd_q.int_end[PW-1:0], cmd_q.int_start[PW-1:0], cmd_q.id};
          res_status_d = ST_OK;
          state_d      = S_DONE;
        end else if (scan_done) begin
          res_status_d = ST_FULL;
          state_d      = S_DONE;
        end
      end
      S_MATCH: begin
        rd_vld_d = rd_issue;
        if (rd_issue) begin
          cnt_d = cnt_q + 1'b1;
        end
        if (better) begin
          found_d    = 1'b1;
          best_idx_d = rd_idx_q;
          best_key_d = e_key;
        end
        if (scan_done) begin
          if (found_q) begin
            state_d = S_REMOVE;
          end else begin
            res_status_d = ST_NOMATCH;
            state_d      = S_DONE;
          end
        end
      end
      S_REMOVE: begin
        mem_we       = 1'b1;
        mem_waddr    = best_idx_q;
        res_status_d = ST_MATCHED;
        res_id_d     = best_key_q[IdW-1:0];
        state_d      = S_DONE;
      end
      S_DONE: begin
        if (!out_vld_q || out_ready_i) begin
          out_vld_d    = 1'b1;
          out_status_d = res_status_q;
          out_id_d     = res_id_q;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_o = out_vld_q;
  assign status_o    = out_status_q;
  assign match_id_o  = out_id_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= mem_q[mem_raddr];
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q     <= mem_raddr;
    cmd_q        <= cmd_d;
    best_idx_q   <= best_idx_d;
    best_key_q   <= best_key_d;
    res_status_q <= res_status_d;
    res_id_q     <= res_id_d;
    out_status_q <= out_status_d;
    out_id_q     <= out_id_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_INIT;
      cnt_q     <= '0;
      rd_vld_q  <= 1'b0;
      found_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      rd_vld_q  <= rd_vld_d;
      found_q   <= found_d;
      out_vld_q <= out_vld_d;
    end
  end

endmodule

`default_nettype wire

FILE: src/convex_bipartite_greedy_match_core.sv
// greedy interval matcher for convex bipartite graphs: the core keeps a table of TABLE_DEPTH
// intervals (id, start, end) and serves three requests, one result word per request word.
// load puts the interval into the lowest free slot (status 0) or reports a full table
// (status 3); clear empties the table (status 0); match takes a point and removes the live
// interval that covers it with the smallest end, then smallest start, then smallest id,
// returning its id (status 1) or no match (status 2); request code 3 does nothing (status 0).
// feed match points in ascending order for the greedy sweep to give a maximum matching.
// start, end and point are cut to POINT_BITS bits (at most 16). the table sits in one
// single-port-read ram scanned one slot per cycle, so a match scans every slot, a load stops
// at the first free slot and a clear writes every slot to not-live. after reset the core
// sweeps the ram before it starts on request words; words are still queued meanwhile.
// a two-word queue in front and a result register behind let both sides stall on their own.

`default_nettype none

module convex_bipartite_greedy_match_core import cbgm_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TableDepthDef,
  parameter int unsigned POINT_BITS  = PointBitsDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // request words
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [ReqW-1:0]    req_type_i,
  input  wire logic [IdW-1:0]     interval_id_i,
  input  wire logic [PtW-1:0]     interval_start_i,
  input  wire logic [PtW-1:0]     interval_end_i,
  input  wire logic [PtW-1:0]     query_point_i,
  // result words
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [StatusW-1:0]      status_o,
  output logic [IdW-1:0]          match_id_o
);

  // command handoff between front queue and back sequencer
  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  // front: decode request type, mask points, queue the command
  cbgm_front #(
    .POINT_BITS (POINT_BITS)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_valid_i      (in_valid_i),
    .req_ready_o      (in_ready_o),
    .req_type_i       (req_type_i),
    .interval_id_i    (interval_id_i),
    .interval_start_i (interval_start_i),
    .interval_end_i   (interval_end_i),
    .query_point_i    (query_point_i),
    .cmd_valid_o      (cmd_valid),
    .cmd_o            (cmd),
    .cmd_pop_i        (cmd_pop)
  );

  // back: slot table ram, scan sequencer and result register
  cbgm_back #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .POINT_BITS  (POINT_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .match_id_o  (match_id_o)
  );

endmodule

`default_nettype wire
